/* sv/amf_pkg.sv */
// amf_pkg: shared types and constants of the adaptive median filter
// no dependencies; imported by every module of the block

package amf_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned IDX_W  = 2 * DIM_W;
  localparam int unsigned ADDR_W = 16;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic [ADDR_W-1:0] caddr;
    logic [IDX_W-1:0]  cidx;
    logic [IDX_W-1:0]  icount;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_t;

endpackage

/* sv/amf_fifo.sv */
// amf_fifo: two-entry queue of centre jobs between front and back
// depends on amf_pkg for job_t

module amf_fifo import amf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* sv/amf_front.sv */
// amf_front: configuration registers, frame counters, line store writes and job issue
// depends on amf_pkg; feeds amf_fifo and the write port of amf_back

module amf_front import amf_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 4,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  input  logic             fifo_full_i,
  input  logic             fifo_empty_i,
  input  logic             back_idle_i,
  output logic             push_o,
  output job_t             job_o,
  output wr_t              wr_o,
  output logic [DIM_W-1:0] width_o,
  output logic [DIM_W-1:0] height_o
);

  localparam int unsigned DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WRST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [DIM_W-1:0] width_q, height_q;
  logic [IDX_W-1:0] in_count_q, out_idx_q;
  logic [DIM_W-1:0] row_q, col_q;
  logic [AW-1:0]    wptr_q, caddr_q;

  logic [IDX_W-1:0] total, lag, icount_n;
  logic             writes, emit, last, acc;
  logic [DIM_W-1:0] cfg_v;

  assign total    = width_q * height_q;
  assign lag      = IDX_W'(MAX_RADIUS) * IDX_W'(width_q) + IDX_W'(MAX_RADIUS);
  assign writes   = (cmd_i == CMD_PIXEL) && (in_count_q < total);
  assign icount_n = writes ? in_count_q + 1'b1 : in_count_q;
  assign emit     = writes ? ((icount_n - out_idx_q) > lag) : (out_idx_q < in_count_q);
  assign last     = (({1'b0, row_q} + 1'b1) >= {1'b0, height_q})
                 && (({1'b0, col_q} + 1'b1) >= {1'b0, width_q});

  assign in_stall_o  = fifo_full_i || (writes && !(fifo_empty_i && back_idle_i));
  assign acc         = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_v       = (cfg_data_i == '0) ? DIM_W'(1) : cfg_data_i;

  assign push_o       = acc && emit;
  assign job_o.row    = row_q;
  assign job_o.col    = col_q;
  assign job_o.caddr  = ADDR_W'(caddr_q);
  assign job_o.cidx   = out_idx_q;
  assign job_o.icount = icount_n;
  assign job_o.last   = last;
  assign wr_o.en      = acc && writes;
  assign wr_o.addr    = ADDR_W'(wptr_q);
  assign wr_o.data    = pixel_in_i;
  assign width_o      = width_q;
  assign height_o     = height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DIM_W'(WRST);
      height_q   <= DIM_W'(1024);
      in_count_q <= '0;
      out_idx_q  <= '0;
      row_q      <= '0;
      col_q      <= '0;
      wptr_q     <= '0;
      caddr_q    <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WIDTH) begin
        width_q <= (32'(cfg_v) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_v;
      end else begin
        height_q <= cfg_v;
      end
      in_count_q <= '0;
      out_idx_q  <= '0;
      row_q      <= '0;
      col_q      <= '0;
      wptr_q     <= '0;
      caddr_q    <= '0;
    end else if (acc) begin
      if (emit && last) begin
        in_count_q <= '0;
        out_idx_q  <= '0;
        row_q      <= '0;
        col_q      <= '0;
        wptr_q     <= '0;
        caddr_q    <= '0;
      end else begin
        in_count_q <= icount_n;
        if (writes) begin
          wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
        end
        if (emit) begin
          out_idx_q <= out_idx_q + 1'b1;
          caddr_q   <= (caddr_q == AW'(DEPTH - 1)) ? '0 : caddr_q + 1'b1;
          if (({1'b0, col_q} + 1'b1) >= {1'b0, width_q}) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* sv/amf_back.sv */
// amf_back: line store memory and window engine, one centre job at a time
// depends on amf_pkg; takes jobs from amf_fifo and writes from amf_front

module amf_back import amf_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 4,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wr_t              wr_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic             fifo_empty_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             idle_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             window_exhausted_o,
  output logic             frame_last_o
);

  localparam int unsigned DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = AW + 2;
  localparam int unsigned DW    = $clog2(MAX_RADIUS + 1) + 1;
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int unsigned PW    = DIM_W + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic signed [DW-1:0] RPOS = DW'(MAX_RADIUS);
  localparam logic signed [DW-1:0] RNEG = -DW'(MAX_RADIUS);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q;

  logic [1:0]              state_q;
  job_t                    job_q;
  logic signed [DW-1:0]    dr_q, dc_q;
  logic [2:0]              pass_q;
  logic signed [SW-1:0]    roff_q;

  logic                    s1_valid_q, s1_in_frame_q, s1_first_q, s1_last_q;
  logic [RW-1:0]           s1_ring_q;
  logic [2:0]              s1_pass_q;

  logic [PIX_W-1:0]        prefix_q [MAX_RADIUS:1];
  logic [CW-1:0]           cnt_q    [MAX_RADIUS:1];
  logic [PIX_W-1:0]        mn_q     [MAX_RADIUS:1];
  logic [PIX_W-1:0]        mx_q     [MAX_RADIUS:1];
  logic [PIX_W-1:0]        centre_q;

  logic signed [SW-1:0]    off, araw;
  logic [AW-1:0]           rd_addr;
  logic signed [PW-1:0]    r, c;
  logic signed [IDX_W:0]   p;
  logic                    in_frame, cell_first, cell_last;
  logic [DW-1:0]           adr, adc;
  logic [RW-1:0]           ring;
  logic [PIX_W-1:0]        val;
  logic [PIX_W-1:0]        res;
  logic                    found;
  logic                    load_out;

  assign off  = roff_q + SW'(dc_q);
  assign araw = $signed({2'b00, job_q.caddr[AW-1:0]}) + off;

  always_comb begin
    if (araw < 0) begin
      rd_addr = AW'(araw + SW'(DEPTH));
    end else if (araw >= $signed(SW'(DEPTH))) begin
      rd_addr = AW'(araw - SW'(DEPTH));
    end else begin
      rd_addr = AW'(araw);
    end
  end

  assign r = $signed({2'b00, job_q.row}) + PW'(dr_q);
  assign c = $signed({2'b00, job_q.col}) + PW'(dc_q);
  assign p = $signed({1'b0, job_q.cidx}) + (IDX_W + 1)'(off);
  assign in_frame = (r >= 0) && (r < $signed({2'b00, height_i}))
                 && (c >= 0) && (c < $signed({2'b00, width_i}))
                 && (p < $signed({1'b0, job_q.icount}));
  assign adr  = (dr_q < 0) ? DW'(-dr_q) : DW'(dr_q);
  assign adc  = (dc_q < 0) ? DW'(-dc_q) : DW'(dc_q);
  assign ring = (adr > adc) ? RW'(adr) : RW'(adc);
  assign cell_first = (dr_q == RNEG) && (dc_q == RNEG);
  assign cell_last  = (dr_q == RPOS) && (dc_q == RPOS);
  assign val = s1_in_frame_q ? rd_q : '0;

  assign idle_o   = (state_q == S_IDLE);
  assign pop_o    = (state_q == S_IDLE) && !fifo_empty_i;
  assign load_out = (state_q == S_DONE) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RUN) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    found = 1'b0;
    res   = centre_q;
    for (int m = 1; m <= MAX_RADIUS; m++) begin
      if (!found && prefix_q[m] != mn_q[m] && prefix_q[m] != mx_q[m]) begin
        found = 1'b1;
        if (centre_q == mn_q[m] || centre_q == mx_q[m]) begin
          res = prefix_q[m];
        end
      end
    end
  end

  // rank passes: one value bit per pass, all radii in parallel
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      for (int m = 1; m <= MAX_RADIUS; m++) begin
        prefix_q[m] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int m = 1; m <= MAX_RADIUS; m++) begin
        logic [PIX_W-1:0] cand;
        logic             inwin;
        logic [CW-1:0]    cnt_n;
        cand  = prefix_q[m] | (PIX_W'(8'h80) >> s1_pass_q);
        inwin = (32'(s1_ring_q) <= m);
        cnt_n = (s1_first_q ? '0 : cnt_q[m]) + CW'(inwin && (val < cand));
        cnt_q[m] <= cnt_n;
        if (s1_last_q && (32'(cnt_n) <= 2 * m * m + 2 * m)) begin
          prefix_q[m] <= cand;
        end
        if (s1_pass_q == 3'd0) begin
          if (inwin && (s1_first_q || val < mn_q[m])) begin
            mn_q[m] <= val;
          end else if (s1_first_q) begin
            mn_q[m] <= '1;
          end
          if (inwin && (s1_first_q || val > mx_q[m])) begin
            mx_q[m] <= val;
          end else if (s1_first_q) begin
            mx_q[m] <= '0;
          end
        end
      end
      if (s1_pass_q == 3'd0 && s1_ring_q == '0) begin
        centre_q <= val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_in_frame_q <= in_frame;
    s1_first_q    <= cell_first;
    s1_last_q     <= cell_last;
    s1_ring_q     <= ring;
    s1_pass_q     <= pass_q;
    if (load_out) begin
      pixel_out_o        <= res;
      window_exhausted_o <= !found;
      frame_last_o       <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dr_q        <= '0;
      dc_q        <= '0;
      pass_q      <= '0;
      roff_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      s1_valid_q <= (state_q == S_RUN);
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            dr_q    <= RNEG;
            dc_q    <= RNEG;
            pass_q  <= '0;
            roff_q  <= -(SW'(MAX_RADIUS) * SW'(width_i));
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (dc_q == RPOS) begin
            dc_q <= RNEG;
            if (dr_q == RPOS) begin
              dr_q   <= RNEG;
              roff_q <= -(SW'(MAX_RADIUS) * SW'(width_i));
              pass_q <= pass_q + 1'b1;
              if (pass_q == 3'd7) begin
                state_q <= S_WAIT;
              end
            end else begin
              dr_q   <= dr_q + 1'b1;
              roff_q <= roff_q + SW'(width_i);
            end
          end else begin
            dc_q <= dc_q + 1'b1;
          end
        end
        S_WAIT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/adaptive_median_filter.sv */
// adaptive_median_filter: top level joining front, job queue and window engine
// depends on amf_pkg, amf_front, amf_fifo and amf_back
//
// Pixels enter in raster order on the input channel (in_valid_i/in_stall_o,
// cmd_i, pixel_in_i); flush items (cmd_i high) drain the pending centres after
// the frame end. Each filtered centre leaves on the output channel
// (out_valid_o/out_stall_i) with its value, an exhausted flag and a frame_last
// flag. Results lag the input by MAX_RADIUS rows plus MAX_RADIUS pixels.
// The window engine makes eight rank passes over the (2*MAX_RADIUS+1)^2 window
// read from the single-port line store, one cell a cycle, and then passes
// through a wait state to the done state, where the result register loads.
// A pixel write waits until the engine and the job queue are empty, so the
// engine finishes one centre before a pixel that issues the next is taken;
// flush items only wait for queue space. The result register holds while
// out_stall_i is high and the engine waits in turn. Reset restores a width
// of MAX_WIDTH capped at 1024 and a height of 1024 and starts a new frame;
// the configuration port (cfg_valid_i/cfg_ready_o) is always ready, and a
// write restarts the frame.

module adaptive_median_filter import amf_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 4,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [PIX_W-1:0] pixel_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] pixel_out_o,
  output logic             window_exhausted_o,
  output logic             frame_last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  job_t             push_job, pop_job;
  wr_t              wr;
  logic             push, pop, full, empty, back_idle;
  logic [DIM_W-1:0] width, height;

  amf_front #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .pixel_in_i  (pixel_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_full_i (full),
    .fifo_empty_i(empty),
    .back_idle_i (back_idle),
    .push_o      (push),
    .job_o       (push_job),
    .wr_o        (wr),
    .width_o     (width),
    .height_o    (height)
  );

  amf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .full_o (full),
    .empty_o(empty)
  );

  amf_back #(
    .MAX_RADIUS(MAX_RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wr_i              (wr),
    .width_i           (width),
    .height_i          (height),
    .fifo_empty_i      (empty),
    .job_i             (pop_job),
    .pop_o             (pop),
    .idle_o            (back_idle),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pixel_out_o       (pixel_out_o),
    .window_exhausted_o(window_exhausted_o),
    .frame_last_o      (frame_last_o)
  );

endmodule
